// File: sv/hrlp_pkg.sv
// ----------------------------------------------------------------------------
// hrlp_pkg
// Types, codes and helper functions shared by the request-line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

  // Characters the parser reacts to
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_S     = 8'h53;

  // Result kinds
  localparam logic [2:0] KIND_PATH   = 3'd0;
  localparam logic [2:0] KIND_KEY    = 3'd1;
  localparam logic [2:0] KIND_VALUE  = 3'd2;
  localparam logic [2:0] KIND_PAIR   = 3'd3;
  localparam logic [2:0] KIND_STATUS = 3'd4;

  // Method codes
  localparam logic [1:0] METH_GET   = 2'd0;
  localparam logic [1:0] METH_POST  = 2'd1;
  localparam logic [1:0] METH_OTHER = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_MALFORMED = 2'd1;
  localparam logic [1:0] STAT_METHOD    = 2'd2;
  localparam logic [1:0] STAT_DECODE    = 2'd3;

  // Method match progress
  localparam logic [2:0] TRK_NONE = 3'd0;
  localparam logic [2:0] TRK_G    = 3'd1;
  localparam logic [2:0] TRK_GE   = 3'd2;
  localparam logic [2:0] TRK_GET  = 3'd3;
  localparam logic [2:0] TRK_P    = 3'd4;
  localparam logic [2:0] TRK_PO   = 3'd5;
  localparam logic [2:0] TRK_POS  = 3'd6;
  localparam logic [2:0] TRK_POST = 3'd7;

  // Percent escape progress
  localparam logic [1:0] ESC_IDLE = 2'd0;
  localparam logic [1:0] ESC_HI   = 2'd1;
  localparam logic [1:0] ESC_LO   = 2'd2;

  localparam int unsigned OUTQ_DEPTH = 4;

  typedef enum logic [6:0] {
    PH_METHOD     = 7'b0000001,
    PH_METHOD_BAD = 7'b0000010,
    PH_PATH       = 7'b0000100,
    PH_QUERY      = 7'b0001000,
    PH_FRAG       = 7'b0010000,
    PH_SKIP       = 7'b0100000,
    PH_DONE       = 7'b1000000
  } hrlp_phase_t;

  typedef struct packed {
    hrlp_phase_t phase;
    logic [2:0]  mtrack;
    logic [1:0]  esc;
    logic [3:0]  hnib;
    logic        key_seen;
    logic        seg_open;
    logic        err;
  } hrlp_state_t;

  localparam hrlp_state_t ST_RESET = '{
    phase:    PH_METHOD,
    mtrack:   TRK_NONE,
    esc:      ESC_IDLE,
    hnib:     4'd0,
    key_seen: 1'b0,
    seg_open: 1'b0,
    err:      1'b0
  };

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [1:0] method;
    logic [1:0] status;
    logic       last;
  } hrlp_item_t;

  // {invalid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
    return r;
  endfunction

  function automatic logic [1:0] method_code(input logic [2:0] trk);
    logic [1:0] r;
    r = METH_OTHER;
    if (trk == TRK_GET) r = METH_GET;
    else if (trk == TRK_POST) r = METH_POST;
    return r;
  endfunction

endpackage

// File: sv/hrlp_step.sv
// ----------------------------------------------------------------------------
// hrlp_step
// Next-state and result logic for one request-line byte (up to two results).
// ----------------------------------------------------------------------------
module hrlp_step
  import hrlp_pkg::*;
(
  input  logic [7:0]  in_byte,
  input  logic        in_start,
  input  hrlp_state_t st_i,
  output hrlp_state_t st_o,
  output hrlp_item_t  res0,
  output hrlp_item_t  res1,
  output logic [1:0]  res_n
);

  hrlp_state_t s;
  logic        do_dec;
  logic [2:0]  dec_kind;
  logic        emit_data;
  logic [7:0]  data_byte;
  logic        emit_pair;
  logic        emit_stat;
  logic [1:0]  stat_meth;
  logic [1:0]  stat_code;
  logic [4:0]  hx;
  logic [2:0]  trk;
  hrlp_item_t  it_first;
  hrlp_item_t  it_stat;

  assign hx = hex_val(in_byte);

  always_comb begin
    s         = in_start ? ST_RESET : st_i;
    do_dec    = 1'b0;
    dec_kind  = KIND_PATH;
    emit_data = 1'b0;
    data_byte = 8'd0;
    emit_pair = 1'b0;
    emit_stat = 1'b0;
    stat_meth = METH_OTHER;
    stat_code = STAT_OK;
    trk       = TRK_NONE;

    unique case (s.phase)
      PH_METHOD, PH_METHOD_BAD: begin
        if (in_byte == CH_CR) begin
          emit_stat = 1'b1;
          stat_meth = METH_OTHER;
          stat_code = STAT_MALFORMED;
          s.phase   = PH_DONE;
        end else if (in_byte == CH_SP) begin
          s.phase = (s.phase == PH_METHOD && method_code(s.mtrack) != METH_OTHER)
                    ? PH_PATH : PH_SKIP;
        end else if (s.phase == PH_METHOD) begin
          unique case (s.mtrack)
            TRK_NONE: trk = (in_byte == CH_G) ? TRK_G :
                            (in_byte == CH_P) ? TRK_P : TRK_NONE;
            TRK_G:    trk = (in_byte == CH_E) ? TRK_GE   : TRK_NONE;
            TRK_GE:   trk = (in_byte == CH_T) ? TRK_GET  : TRK_NONE;
            TRK_P:    trk = (in_byte == CH_O) ? TRK_PO   : TRK_NONE;
            TRK_PO:   trk = (in_byte == CH_S) ? TRK_POS  : TRK_NONE;
            TRK_POS:  trk = (in_byte == CH_T) ? TRK_POST : TRK_NONE;
            default:  trk = TRK_NONE;
          endcase
          // no progress means the method can no longer match
          if (trk == TRK_NONE) s.phase = PH_METHOD_BAD;
          else s.mtrack = trk;
        end
      end
      PH_SKIP: begin
        if (in_byte == CH_CR || in_byte == CH_SP) begin
          emit_stat = 1'b1;
          stat_meth = METH_OTHER;
          stat_code = STAT_METHOD;
          s.phase   = PH_DONE;
        end
      end
      PH_PATH, PH_QUERY, PH_FRAG: begin
        if (in_byte == CH_CR) begin
          emit_stat = 1'b1;
          stat_meth = method_code(s.mtrack);
          stat_code = STAT_MALFORMED;
          s.phase   = PH_DONE;
        end else if (in_byte == CH_SP) begin
          if (s.phase == PH_PATH || s.phase == PH_QUERY) begin
            if (s.esc != ESC_IDLE) s.err = 1'b1;
            s.esc = ESC_IDLE;
          end
          if (s.phase == PH_QUERY) begin
            if (s.seg_open) begin
              if (!s.key_seen) s.err = 1'b1;
              if (!s.err) emit_pair = 1'b1;
            end
            s.seg_open = 1'b0;
            s.key_seen = 1'b0;
          end
          emit_stat = 1'b1;
          stat_meth = method_code(s.mtrack);
          stat_code = s.err ? STAT_DECODE : STAT_OK;
          s.phase   = PH_DONE;
        end else if (s.phase == PH_PATH) begin
          if (in_byte == CH_QUEST || in_byte == CH_HASH) begin
            if (s.esc != ESC_IDLE) s.err = 1'b1;
            s.esc      = ESC_IDLE;
            s.seg_open = 1'b0;
            s.key_seen = 1'b0;
            s.phase    = (in_byte == CH_QUEST) ? PH_QUERY : PH_FRAG;
          end else begin
            do_dec   = 1'b1;
            dec_kind = KIND_PATH;
          end
        end else if (s.phase == PH_QUERY) begin
          if (in_byte == CH_AMP || in_byte == CH_HASH) begin
            if (s.esc != ESC_IDLE) s.err = 1'b1;
            s.esc = ESC_IDLE;
            if (s.seg_open) begin
              if (!s.key_seen) s.err = 1'b1;
              if (!s.err) emit_pair = 1'b1;
            end
            s.seg_open = 1'b0;
            s.key_seen = 1'b0;
            if (in_byte == CH_HASH) s.phase = PH_FRAG;
          end else if (in_byte == CH_EQ && !s.key_seen) begin
            // '=' opening a segment means an empty key
            if (!s.seg_open) s.err = 1'b1;
            if (s.esc != ESC_IDLE) s.err = 1'b1;
            s.esc      = ESC_IDLE;
            s.key_seen = 1'b1;
            s.seg_open = 1'b1;
          end else begin
            s.seg_open = 1'b1;
            do_dec     = 1'b1;
            dec_kind   = s.key_seen ? KIND_VALUE : KIND_KEY;
          end
        end
      end
      default: ;
    endcase

    // URL decode of one byte
    if (do_dec) begin
      if (s.err) begin
        s.esc = ESC_IDLE;
      end else if (s.esc == ESC_HI) begin
        if (hx[4]) begin
          s.err = 1'b1;
          s.esc = ESC_IDLE;
        end else begin
          s.hnib = hx[3:0];
          s.esc  = ESC_LO;
        end
      end else if (s.esc == ESC_LO) begin
        s.esc = ESC_IDLE;
        if (hx[4]) begin
          s.err = 1'b1;
        end else begin
          emit_data = 1'b1;
          data_byte = {s.hnib, hx[3:0]};
        end
      end else if (in_byte == CH_PLUS) begin
        emit_data = 1'b1;
        data_byte = CH_SP;
      end else if (in_byte == CH_PCT) begin
        s.esc = ESC_HI;
      end else begin
        emit_data = 1'b1;
        data_byte = in_byte;
      end
    end
  end

  // data and pair end never come from the same byte; status always goes last
  always_comb begin
    it_first = '0;
    if (emit_pair) begin
      it_first.kind = KIND_PAIR;
    end else begin
      it_first.kind = dec_kind;
      it_first.data = data_byte;
    end
    it_stat        = '0;
    it_stat.kind   = KIND_STATUS;
    it_stat.method = stat_meth;
    it_stat.status = stat_code;
    it_stat.last   = 1'b1;
  end

  always_comb begin
    st_o = s;
    if (emit_pair || emit_data) begin
      res0  = it_first;
      res1  = it_stat;
      res_n = emit_stat ? 2'd2 : 2'd1;
    end else begin
      res0  = it_stat;
      res1  = '0;
      res_n = emit_stat ? 2'd1 : 2'd0;
    end
  end

endmodule

// File: sv/hrlp_outq.sv
// ----------------------------------------------------------------------------
// hrlp_outq
// Small result queue: takes up to two items a cycle, hands out one when popped.
// ----------------------------------------------------------------------------
module hrlp_outq
  import hrlp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  hrlp_item_t push0,
  input  hrlp_item_t push1,
  input  logic [1:0] push_n,
  output logic       room,
  output logic       head_valid,
  output hrlp_item_t head,
  input  logic       pop
);

  localparam int unsigned PW = $clog2(OUTQ_DEPTH);

  hrlp_item_t      mem_r [OUTQ_DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt;
  logic [PW-1:0]   rd_r, rd_nxt;
  logic [PW:0]     cnt_r, cnt_nxt;
  logic [PW-1:0]   wr_p1;
  logic            do_pop;

  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_r];
  // two free slots needed for the worst case byte
  assign room       = (cnt_r <= (PW+1)'(OUTQ_DEPTH - 2));
  assign do_pop     = pop && head_valid;
  assign wr_p1      = wr_r + PW'(1);

  always_comb begin
    wr_nxt  = wr_r + PW'(push_n);
    rd_nxt  = rd_r + PW'(do_pop);
    cnt_nxt = cnt_r + (PW+1)'(push_n) - (PW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem_r[wr_r] <= push0;
    if (push_n == 2'd2) mem_r[wr_p1] <= push1;
  end

endmodule

// File: sv/http_request_line_parser_core.sv
// ----------------------------------------------------------------------------
// http_request_line_parser_core
// HTTP request-line parser with URL decoding of path, keys and values.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one raw request-line byte per item,
//   in_start high on the first byte of each request.
//   Result channel (out_valid / out_stall): decoded path, key and value
//   bytes, pair-end markers and one closing status item (out_last high).
//   A byte is taken every cycle while in_stall is low; it is decoded in
//   the cycle it is accepted and its results are registered in a
//   four-entry result queue whose head drives the result port.
//   A byte yields at most two results (pair end plus status); the result
//   port hands out one per cycle while out_stall is low, so a stream of
//   such bytes fills the queue, all other bytes run at one byte per cycle.
//   in_stall rises when the queue has fewer than two free entries, so a
//   stalled receiver fills the queue and then holds the input side.
//   Reset clears the parser state to the method phase and empties the
//   queue. On any error status the emitted bytes of that request are void.
// ----------------------------------------------------------------------------
module http_request_line_parser_core
  import hrlp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_byte,
  output logic [1:0] out_method,
  output logic [1:0] out_status,
  output logic       out_last
);

  hrlp_state_t st_r, st_nxt;
  hrlp_item_t  res0, res1, head;
  logic [1:0]  res_n;
  logic [1:0]  push_n;
  logic        room;
  logic        in_acc;

  assign in_stall = !room;
  assign in_acc   = in_valid && room;
  assign push_n   = in_acc ? res_n : 2'd0;

  hrlp_step u_step (
    .in_byte  (in_byte),
    .in_start (in_start),
    .st_i     (st_r),
    .st_o     (st_nxt),
    .res0     (res0),
    .res1     (res1),
    .res_n    (res_n)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_RESET;
    else if (in_acc) st_r <= st_nxt;
  end

  hrlp_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push0      (res0),
    .push1      (res1),
    .push_n     (push_n),
    .room       (room),
    .head_valid (out_valid),
    .head       (head),
    .pop        (!out_stall)
  );

  assign out_kind   = head.kind;
  assign out_byte   = head.data;
  assign out_method = head.method;
  assign out_status = head.status;
  assign out_last   = head.last;

endmodule

// File: dv/http_request_line_parser_core_checker.sv
// ----------------------------------------------------------------------------
// http_request_line_parser_core_checker
// Watches both channels of the request-line parser. Every accepted byte runs
// through a cycle-free copy of the parser, which queues the results it
// expects; every accepted result is compared field by field with the oldest
// of them. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module http_request_line_parser_core_checker
  import hrlp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [7:0]        in_byte,
  input  logic              in_start,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [2:0]        out_kind,
  input  logic [7:0]        out_byte,
  input  logic [1:0]        out_method,
  input  logic [1:0]        out_status,
  input  logic              out_last,
  output int unsigned       mismatch_count,
  output int unsigned       pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  hrlp_item_t  pending_results[$];

  // parser state as seen by the predictor
  hrlp_phase_t ph;
  logic [2:0]  trk;
  logic [1:0]  esc;
  logic [3:0]  hi_nib;
  logic        key_seen;
  logic        seg_open;
  logic        dec_err;

  initial mismatch_count = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR %s", $time, msg);
    mismatch_count = mismatch_count + 1;
  endtask

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
    if (lc >= "a" && lc <= "f") return {1'b0, lc[3:0] + 4'd9};
    return 5'h10;
  endfunction

  function automatic logic [1:0] method_of(input logic [2:0] t);
    if (t == TRK_GET) return METH_GET;
    if (t == TRK_POST) return METH_POST;
    return METH_OTHER;
  endfunction

  task automatic clear_state();
    ph       = PH_METHOD;
    trk      = TRK_NONE;
    esc      = ESC_IDLE;
    hi_nib   = 4'd0;
    key_seen = 1'b0;
    seg_open = 1'b0;
    dec_err  = 1'b0;
  endtask

  task automatic emit(input logic [2:0] kind, input logic [7:0] data,
                      input logic [1:0] meth, input logic [1:0] stat,
                      input logic last);
    hrlp_item_t it;
    it.kind   = kind;
    it.data   = data;
    it.method = meth;
    it.status = stat;
    it.last   = last;
    pending_results.push_back(it);
  endtask

  task automatic close_escape();
    if (esc != ESC_IDLE) dec_err = 1'b1;
    esc = ESC_IDLE;
  endtask

  task automatic close_segment();
    close_escape();
    if (seg_open) begin
      if (!key_seen) dec_err = 1'b1;
      if (!dec_err) emit(KIND_PAIR, '0, '0, '0, 1'b0);
    end
    seg_open = 1'b0;
    key_seen = 1'b0;
  endtask

  // URL decoding of one path, key or value byte
  task automatic decode_char(input logic [7:0] c, input logic [2:0] kind);
    logic [4:0] h;
    h = hex_digit(c);
    if (dec_err) begin
      esc = ESC_IDLE;
    end else if (esc == ESC_HI) begin
      if (h[4]) begin
        dec_err = 1'b1;
        esc = ESC_IDLE;
      end else begin
        hi_nib = h[3:0];
        esc = ESC_LO;
      end
    end else if (esc == ESC_LO) begin
      esc = ESC_IDLE;
      if (h[4]) dec_err = 1'b1;
      else emit(kind, {hi_nib, h[3:0]}, '0, '0, 1'b0);
    end else if (c == CH_PLUS) begin
      emit(kind, CH_SP, '0, '0, 1'b0);
    end else if (c == CH_PCT) begin
      esc = ESC_HI;
    end else begin
      emit(kind, c, '0, '0, 1'b0);
    end
  endtask

  task automatic parse_byte(input logic [7:0] c, input logic start);
    logic [2:0] nxt;
    logic       bad;
    if (start) clear_state();
    case (ph)
      PH_METHOD, PH_METHOD_BAD: begin
        if (c == CH_CR) begin
          emit(KIND_STATUS, '0, METH_OTHER, STAT_MALFORMED, 1'b1);
          ph = PH_DONE;
        end else if (c == CH_SP) begin
          ph = (ph == PH_METHOD && method_of(trk) != METH_OTHER) ? PH_PATH : PH_SKIP;
        end else if (ph == PH_METHOD) begin
          bad = 1'b1;
          nxt = trk;
          case (trk)
            TRK_NONE: begin
              if (c == CH_G) begin
                nxt = TRK_G;
                bad = 1'b0;
              end else if (c == CH_P) begin
                nxt = TRK_P;
                bad = 1'b0;
              end
            end
            TRK_G:   if (c == CH_E) {bad, nxt} = {1'b0, TRK_GE};
            TRK_GE:  if (c == CH_T) {bad, nxt} = {1'b0, TRK_GET};
            TRK_P:   if (c == CH_O) {bad, nxt} = {1'b0, TRK_PO};
            TRK_PO:  if (c == CH_S) {bad, nxt} = {1'b0, TRK_POS};
            TRK_POS: if (c == CH_T) {bad, nxt} = {1'b0, TRK_POST};
            default: ;
          endcase
          if (bad) ph = PH_METHOD_BAD;
          else trk = nxt;
        end
      end
      PH_SKIP: begin
        if (c == CH_CR || c == CH_SP) begin
          emit(KIND_STATUS, '0, METH_OTHER, STAT_METHOD, 1'b1);
          ph = PH_DONE;
        end
      end
      PH_PATH, PH_QUERY, PH_FRAG: begin
        if (c == CH_CR) begin
          emit(KIND_STATUS, '0, method_of(trk), STAT_MALFORMED, 1'b1);
          ph = PH_DONE;
        end else if (c == CH_SP) begin
          if (ph == PH_PATH) close_escape();
          else if (ph == PH_QUERY) close_segment();
          emit(KIND_STATUS, '0, method_of(trk), dec_err ? STAT_DECODE : STAT_OK, 1'b1);
          ph = PH_DONE;
        end else if (ph == PH_PATH) begin
          if (c == CH_QUEST || c == CH_HASH) begin
            close_escape();
            seg_open = 1'b0;
            key_seen = 1'b0;
            ph = (c == CH_QUEST) ? PH_QUERY : PH_FRAG;
          end else begin
            decode_char(c, KIND_PATH);
          end
        end else if (ph == PH_QUERY) begin
          if (c == CH_AMP || c == CH_HASH) begin
            close_segment();
            if (c == CH_HASH) ph = PH_FRAG;
          end else if (c == CH_EQ && !key_seen) begin
            // first raw '=' splits key from value
            if (!seg_open) dec_err = 1'b1;
            close_escape();
            key_seen = 1'b1;
            seg_open = 1'b1;
          end else begin
            seg_open = 1'b1;
            decode_char(c, key_seen ? KIND_VALUE : KIND_KEY);
          end
        end
        // fragment bytes are dropped
      end
      default: ;
    endcase
  endtask

  task automatic compare_result();
    hrlp_item_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d byte %02h status %0d",
                                out_kind, out_byte, out_status));
    end else begin
      want = pending_results.pop_front();
      if (out_kind !== want.kind)
        report_mismatch($sformatf("kind got %0d want %0d", out_kind, want.kind));
      if (out_byte !== want.data)
        report_mismatch($sformatf("byte got %02h want %02h", out_byte, want.data));
      if (out_method !== want.method)
        report_mismatch($sformatf("method got %0d want %0d", out_method, want.method));
      if (out_status !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
      if (out_last !== want.last)
        report_mismatch($sformatf("last got %0d want %0d", out_last, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      pending_results.delete();
    end else begin
      // a byte's results are registered in the result queue before they show up
      if (in_valid && !in_stall) parse_byte(in_byte, in_start);
      if (out_valid && !out_stall) compare_result();
    end
    pending_count <= pending_results.size();
  end

endmodule

// File: dv/http_request_line_parser_core_tb.sv
// ----------------------------------------------------------------------------
// http_request_line_parser_core_tb
// Feeds the request-line parser with directed lines, then with random
// request lines (valid methods, escapes, query pairs, fragments, broken
// lines) and raw noise, under random idling on both channels and one long
// receiver hold-off. The checker predicts and compares; this top gives the
// verdict.
// ----------------------------------------------------------------------------
module http_request_line_parser_core_tb;
  import hrlp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RAND_ITEMS = 1100;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_start;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] out_kind;
  logic [7:0] out_byte;
  logic [1:0] out_method;
  logic [1:0] out_status;
  logic       out_last;

  int unsigned mismatches;
  int unsigned pending;

  logic [7:0]  line_bytes[$];
  int unsigned body_total;
  bit          calm;
  bit          hold_req;

  http_request_line_parser_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .in_start   (in_start),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_byte   (out_byte),
    .out_method (out_method),
    .out_status (out_status),
    .out_last   (out_last)
  );

  http_request_line_parser_core_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_start       (in_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_method     (out_method),
    .out_status     (out_status),
    .out_last       (out_last),
    .mismatch_count (mismatches),
    .pending_count  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic put(input logic [7:0] b);
    line_bytes.push_back(b);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endtask

  function automatic logic [7:0] hex_char();
    int unsigned v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'(8'h30 + v);
    return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10);
  endfunction

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // one raw URI character, possibly an escape of two or three bytes
  task automatic put_uri_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      put(pick("abcxyzXYZ019-_./~"));
    end else if (r < 63) begin
      put(CH_PLUS);
    end else if (r < 80) begin
      put(CH_PCT);
      put(hex_char());
      put(hex_char());
    end else if (r < 83) begin
      // broken escape: bad digit or cut short
      put(CH_PCT);
      if ($urandom_range(0, 1)) put(hex_char());
      put(pick("gGz%&= "));
    end else if (r < 95) begin
      put(8'($urandom_range(8'h21, 8'h7E)));
    end else begin
      put(8'($urandom_range(8'h80, 8'hFF)));
    end
  endtask

  task automatic build_request();
    int unsigned r;
    int unsigned nseg;
    line_bytes.delete();
    r = $urandom_range(0, 99);
    if (r < 80) begin
      put_text($urandom_range(0, 1) ? "GET" : "POST");
    end else if (r < 92) begin
      repeat ($urandom_range(1, 5)) put(pick("GETPOSX"));
    end else if (r < 96) begin
      repeat ($urandom_range(0, 4)) put(pick("GETPOS"));
      put(CH_CR);
      return;
    end
    put(CH_SP);
    if ($urandom_range(0, 9) != 0) put("/");
    repeat ($urandom_range(0, 6)) put_uri_char();
    if ($urandom_range(0, 1)) begin
      put(CH_QUEST);
      nseg = $urandom_range(0, 3);
      for (int s = 0; s < nseg; s++) begin
        if (s > 0) put(CH_AMP);
        if ($urandom_range(0, 7) == 0) put(CH_AMP);
        repeat ($urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 3)) put_uri_char();
        if ($urandom_range(0, 9) != 0) put(CH_EQ);
        repeat ($urandom_range(0, 3)) put_uri_char();
      end
    end
    if ($urandom_range(0, 4) == 0) begin
      put(CH_HASH);
      repeat ($urandom_range(0, 4)) put(pick("?&=#a%+"));
    end
    r = $urandom_range(0, 19);
    if (r < 16) put(CH_SP);
    else if (r < 19) put(CH_CR);
    // else the line is cut and the next request restarts the parser
  endtask

  task automatic send_byte(input logic [7:0] b, input logic s);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_start <= s;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_line(input bit noisy);
    foreach (line_bytes[i])
      send_byte(line_bytes[i], noisy ? 1'($urandom_range(0, 1)) : 1'(i == 0));
  endtask

  task automatic send_text(input string s, input bit with_cr);
    line_bytes.delete();
    put_text(s);
    if (with_cr) put(CH_CR);
    send_line(1'b0);
  endtask

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (120) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned guard;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_byte  <= '0;
    in_start <= 1'b0;
    calm     = 1'b0;
    hold_req = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // GET, plus, hex in both cases, raw extremes, empty segment, value with
    // '=', fragment, trailing bytes ignored
    line_bytes.delete();
    put_text("GET /+%4a%Ff");
    put(8'hFF);
    put(8'h00);
    put_text("?k=%7e&&b=c=d#z? HTTP");
    put(CH_CR);
    send_line(1'b0);
    send_text("POST /?=v ", 1'b0);      // empty key
    send_text("POST /?k&x=1", 1'b1);    // no '=', then CR before second space
    send_text("GET /%4g ", 1'b0);       // bad hex digit
    send_text("GET /a%4?b=1 ", 1'b0);   // escape cut by '?'
    send_text("PUT / ", 1'b0);          // unsupported method
    send_text("GE", 1'b1);              // CR inside the method
    send_text(" x ", 1'b0);             // empty method

    hold_req = 1'b1;
    body_total = 0;
    while (body_total < RAND_ITEMS) begin
      calm = (body_total + 150 > RAND_ITEMS) || ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 11) == 0) begin
        line_bytes.delete();
        repeat ($urandom_range(1, 10)) put(8'($urandom_range(0, 255)));
        body_total += line_bytes.size();
        send_line(1'b1);
      end else begin
        build_request();
        if ($urandom_range(0, 3) == 0) begin
          put_text(" HTTP/1.1");
          put(CH_CR);
        end
        body_total += line_bytes.size();
        send_line(1'b0);
      end
    end
    in_valid <= 1'b0;

    repeat (2) @(posedge clk);
    guard = 0;
    while (pending != 0 && guard < 4000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (pending != 0) $display("ERROR %0d expected results never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
